// ===== design/afc_pkg.sv =====
// ============================================================================
// afc_pkg
// Shared widths, register layout and handoff types for the six-plane
// box-versus-frustum cull pipeline.
// ============================================================================
package afc_pkg;

    // plane count and config index width
    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // field widths
    localparam int COORD_W = 22;   // signed Q13.8
    localparam int HALF_W  = 21;   // unsigned Q13.8
    localparam int NORM_W  = 14;   // signed Q1.12
    localparam int DIST_W  = 22;   // signed Q13.8

    // plane register layout
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 14;
    localparam int NZ_LSB = 28;
    localparam int D_LSB  = 42;

    // normal fraction bits: distance is shifted up by this to align with products
    localparam int NORM_FRAC = 12;

    // product and accumulator widths
    localparam int PROD_W = NORM_W + COORD_W;   // 36, signed
    localparam int ACC_W  = 40;                 // holds any partial or total sum

    // box request moving from cell to cell
    typedef struct packed {
        logic                       valid;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cz;
        logic        [HALF_W-1:0]   hx;
        logic        [HALF_W-1:0]   hy;
        logic        [HALF_W-1:0]   hz;
    } t_box;

    // running verdict leaving a cell
    typedef struct packed {
        logic valid;
        logic vis;
    } t_res;

endpackage

// ===== design/afc_plane_cell.sv =====
// ============================================================================
// afc_plane_cell
// One plane of the cull chain: holds its plane register, tests the box that
// passes through and ANDs its verdict into the running visible flag.
// ============================================================================
module afc_plane_cell
    import afc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_DATA_W-1:0] i_data,
    input  t_box                  i_box,
    input  logic                  i_vis,
    output t_box                  o_box,
    output t_res                  o_res
);

    // plane register, with normal magnitudes kept alongside
    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic        [NORM_W-1:0] r_ax, r_ay, r_az;
    logic signed [DIST_W-1:0] r_d;

    logic signed [NORM_W-1:0] n_nx, n_ny, n_nz;

    // stage registers
    t_box                     r_box;
    logic                     r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [PROD_W-1:0] r_rx, r_ry, r_rz;
    logic signed [ACC_W-1:0]  r_a, r_b;
    logic                     r_vis;

    logic signed [PROD_W-1:0] n_px, n_py, n_pz;
    logic signed [PROD_W-1:0] n_rx, n_ry, n_rz;
    logic signed [ACC_W-1:0]  n_a, n_b, n_sum;

    // unpack incoming plane word
    assign n_nx = i_data[NX_LSB +: NORM_W];
    assign n_ny = i_data[NY_LSB +: NORM_W];
    assign n_nz = i_data[NZ_LSB +: NORM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= '0;
            r_ax <= '0;
            r_ay <= '0;
            r_az <= '0;
            r_d  <= '0;
        end else if (i_we) begin
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_nz <= n_nz;
            r_ax <= n_nx[NORM_W-1] ? NORM_W'(-n_nx) : NORM_W'(n_nx);
            r_ay <= n_ny[NORM_W-1] ? NORM_W'(-n_ny) : NORM_W'(n_ny);
            r_az <= n_nz[NORM_W-1] ? NORM_W'(-n_nz) : NORM_W'(n_nz);
            r_d  <= i_data[D_LSB +: DIST_W];
        end
    end

    // stage 1 products: center dot normal, extents dot |normal|
    assign n_px = PROD_W'(r_nx) * PROD_W'(i_box.cx);
    assign n_py = PROD_W'(r_ny) * PROD_W'(i_box.cy);
    assign n_pz = PROD_W'(r_nz) * PROD_W'(i_box.cz);
    assign n_rx = $signed(PROD_W'(r_ax)) * $signed(PROD_W'(i_box.hx));
    assign n_ry = $signed(PROD_W'(r_ay)) * $signed(PROD_W'(i_box.hy));
    assign n_rz = $signed(PROD_W'(r_az)) * $signed(PROD_W'(i_box.hz));

    // stage 2 partial sums, distance aligned to product scale
    assign n_a = ACC_W'(r_px) + ACC_W'(r_py) + ACC_W'(r_pz);
    assign n_b = ACC_W'(r_rx) + ACC_W'(r_ry) + ACC_W'(r_rz)
               - (ACC_W'(r_d) <<< NORM_FRAC);

    // stage 3 final sign test
    assign n_sum = r_a + r_b;

    // pipeline payload and valids
    always_ff @(posedge i_clk) begin
        r_box.cx <= i_box.cx;
        r_box.cy <= i_box.cy;
        r_box.cz <= i_box.cz;
        r_box.hx <= i_box.hx;
        r_box.hy <= i_box.hy;
        r_box.hz <= i_box.hz;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pz     <= n_pz;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_rz     <= n_rz;
        r_a      <= n_a;
        r_b      <= n_b;
        r_vis    <= i_vis & ~n_sum[ACC_W-1];
        if (!i_rst_n) begin
            r_box.valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_box.valid <= i_box.valid;
            r_v1        <= i_box.valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
        end
    end

    assign o_box     = r_box;
    assign o_res.valid = r_v3;
    assign o_res.vis   = r_vis;

    // verdict can only be cleared along the chain, never set
    a_vis_and: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.vis) |-> $past(i_vis))
        else $error("cell verdict set without upstream visible");

    // plane register takes the written word
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |=> (r_d == $past(i_data[D_LSB +: DIST_W])) && (r_nx == $past(n_nx)))
        else $error("plane register write lost");

    // verdict trails the box by three stages
    a_res_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $past(i_box.valid, 3))
        else $error("verdict without matching box");

endmodule

// ===== design/aabb_frustum_cull_test.sv =====
// ============================================================================
// aabb_frustum_cull_test
// Six-plane frustum cull of axis-aligned boxes: a chain of plane cells, one
// box entering per cycle, one visible flag out per box.
// ============================================================================
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  request   | start / busy              | i_center_x/y/z, i_half_x/y/z
//  result    | o_valid (strobe)          | o_visible
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A request is taken in any cycle; busy stays low, so one box per clock.
//  The result strobe follows the request through the input register, the box
//  register of each earlier cell, and then the last cell's three stages.
//  Reset clears all valids and the six plane registers (every box then passes).
//  The receiver cannot stall; results leave on the strobe cycle only.
module aabb_frustum_cull_test
    import afc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic        [HALF_W-1:0]  i_half_x,
    input  logic        [HALF_W-1:0]  i_half_y,
    input  logic        [HALF_W-1:0]  i_half_z,
    output logic                      o_valid,
    output logic                      o_visible,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_box r_box;
    t_box w_box [NUM_PLANES+1];
    logic w_vis [NUM_PLANES+1];
    t_res w_res [NUM_PLANES];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        r_box.cx <= i_center_x;
        r_box.cy <= i_center_y;
        r_box.cz <= i_center_z;
        r_box.hx <= i_half_x;
        r_box.hy <= i_half_y;
        r_box.hz <= i_half_z;
        if (!i_rst_n) begin
            r_box.valid <= 1'b0;
        end else begin
            r_box.valid <= start & ~busy;
        end
    end

    assign w_box[0] = r_box;
    assign w_vis[0] = 1'b1;

    // chain of plane cells
    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        afc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_IDX_W'(k))),
            .i_data  (i_cfg_data),
            .i_box   (w_box[k]),
            .i_vis   (w_vis[k]),
            .o_box   (w_box[k+1]),
            .o_res   (w_res[k])
        );
        assign w_vis[k+1] = w_res[k].vis;
    end

    // result from last cell
    assign o_valid   = w_res[NUM_PLANES-1].valid;
    assign o_visible = w_vis[NUM_PLANES];

    // every request gives a result
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##9 o_valid)
        else $error("request without result");

    // no result without a request
    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 9))
        else $error("result without request");

    // pipeline empties on reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule

// ===== tb/sv/aabb_frustum_cull_test_test.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_test
// Self-checking bench for the six-plane box cull. Boxes go in on start/busy
// and are scored against a bit-accurate predictor that holds its own copy of
// the plane registers. Directed cases cover reset planes, boxes that just touch
// a plane, extreme plane and box values and writes to unused register indexes.
// Random phases then reprogram the planes and stream boxes with idle bursts.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_test;
    import afc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request edge to result strobe, in cycles
    localparam int LATENCY      = 9;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 11;
    localparam int PHASE_BOXES  = 150;
    localparam longint TIMEOUT_NS = 3_000_000;

    localparam logic signed [COORD_W-1:0] C_MAX = 22'sh1FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 22'sh200000;
    localparam logic [HALF_W-1:0]         H_MAX = 21'h1FFFFF;
    localparam logic signed [NORM_W-1:0]  N_ONE = 14'sd4096;
    localparam logic signed [NORM_W-1:0]  N_MAX = 14'sh1FFF;
    localparam logic signed [NORM_W-1:0]  N_MIN = 14'sh2000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_TOP    = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5,
        REG_SPARE6 = 3'd6,
        REG_SPARE7 = 3'd7
    } t_plane_reg;

    // how a random plane is built
    typedef enum int {
        PLANE_OPEN,
        PLANE_AXIS,
        PLANE_TILTED,
        PLANE_RAW
    } t_plane_kind;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_center_x;
    logic signed [COORD_W-1:0] i_center_y;
    logic signed [COORD_W-1:0] i_center_z;
    logic        [HALF_W-1:0]  i_half_x;
    logic        [HALF_W-1:0]  i_half_y;
    logic        [HALF_W-1:0]  i_half_z;
    logic                      o_valid;
    logic                      o_visible;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    // plane registers as the block should hold them, and the next set to load
    logic [CFG_DATA_W-1:0] plane_copy  [NUM_PLANES];
    logic [CFG_DATA_W-1:0] planes_next [NUM_PLANES];

    bit expected_visible_q [$];
    int mismatch_count;
    int boxes_sent;
    int results_seen;
    int visible_seen;
    int plane_settings;

    aabb_frustum_cull_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_half_x    (i_half_x),
        .i_half_y    (i_half_y),
        .i_half_z    (i_half_z),
        .o_valid     (o_valid),
        .o_visible   (o_visible),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still outstanding", expected_visible_q.size());
        $display("Mismatches found");
        $finish;
    end

    // six-plane visibility of one box under the current plane copy
    function automatic bit predict_visible(
        input logic signed [COORD_W-1:0] cx, cy, cz,
        input logic        [HALF_W-1:0]  hx, hy, hz
    );
        longint nx, ny, nz, d, radius, sdist;
        longint cxl, cyl, czl, hxl, hyl, hzl;
        bit     vis;
        cxl = cx;
        cyl = cy;
        czl = cz;
        hxl = hx;
        hyl = hy;
        hzl = hz;
        vis = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            nx   = $signed(plane_copy[i][NX_LSB +: NORM_W]);
            ny   = $signed(plane_copy[i][NY_LSB +: NORM_W]);
            nz   = $signed(plane_copy[i][NZ_LSB +: NORM_W]);
            d    = $signed(plane_copy[i][D_LSB +: DIST_W]);
            radius = hxl * (nx < 0 ? -nx : nx) + hyl * (ny < 0 ? -ny : ny)
                   + hzl * (nz < 0 ? -nz : nz);
            sdist  = nx * cxl + ny * cyl + nz * czl - (d <<< NORM_FRAC);
            if (sdist + radius < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_plane(
        input logic signed [NORM_W-1:0] nx, ny, nz,
        input logic signed [DIST_W-1:0] d
    );
        return {d, nz, ny, nx};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_plane(input t_plane_kind kind);
        logic signed [NORM_W-1:0] n [3];
        logic signed [DIST_W-1:0] d;
        int                       axis;
        n[0] = '0;
        n[1] = '0;
        n[2] = '0;
        case (kind)
            PLANE_OPEN: begin
                // zero normal with distance at or below zero always passes
                d = -$signed({1'b0, 21'($urandom_range(0, 2**21 - 1))});
                if ($urandom_range(0, 7) == 0)
                    d = C_MIN;
            end
            PLANE_AXIS: begin
                axis    = $urandom_range(0, 2);
                n[axis] = $urandom_range(0, 1) ? N_ONE : -N_ONE;
                d       = DIST_W'(int'($urandom_range(0, 2**17)) - 2**16);
            end
            PLANE_TILTED: begin
                n[0] = NORM_W'($urandom);
                n[1] = NORM_W'($urandom);
                n[2] = NORM_W'($urandom);
                d    = DIST_W'(int'($urandom_range(0, 2**17)) - 2**16);
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
        return pack_plane(n[0], n[1], n[2], d);
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        mismatch_count++;
        $display("ERROR at %0t: %s, expected %0d got %0d", $realtime, what, exp_val, got_val);
    endtask

    // result checker: every strobe is scored against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_visible === 1'b1)
                visible_seen++;
            if (expected_visible_q.size() == 0) begin
                report_mismatch("result strobe with no request outstanding", 0, o_visible);
            end else begin
                bit exp_vis;
                exp_vis = expected_visible_q.pop_front();
                if (o_visible !== exp_vis)
                    report_mismatch($sformatf("visible of result %0d", results_seen),
                                    exp_vis, o_visible);
            end
        end
    end

    // one box request; start is left high so the next one can follow at once
    task automatic send_box(
        input logic signed [COORD_W-1:0] cx, cy, cz,
        input logic        [HALF_W-1:0]  hx, hy, hz
    );
        @(negedge i_clk);
        start      = 1'b1;
        i_center_x = cx;
        i_center_y = cy;
        i_center_z = cz;
        i_half_x   = hx;
        i_half_y   = hy;
        i_half_z   = hz;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_visible_q.push_back(predict_visible(cx, cy, cz, hx, hy, hz));
        boxes_sent++;
    endtask

    // sender idle burst with junk on the payload
    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start      = 1'b0;
        i_center_x = COORD_W'($urandom);
        i_center_y = COORD_W'($urandom);
        i_center_z = COORD_W'($urandom);
        i_half_x   = HALF_W'($urandom);
        i_half_y   = HALF_W'($urandom);
        i_half_z   = HALF_W'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_visible_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_plane_reg idx, input logic [CFG_DATA_W-1:0] data);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx < NUM_PLANES)
            plane_copy[idx] = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = {$urandom, $urandom};
    endtask

    // load planes_next into all six registers once the block is idle
    task automatic program_planes();
        wait_drained();
        for (int i = 0; i < NUM_PLANES; i++)
            write_cfg(t_plane_reg'(i), planes_next[i]);
        plane_settings++;
    endtask

    // reset planes pass every box, extremes included
    task automatic test_reset_planes();
        send_box('0, '0, '0, '0, '0, '0);
        send_box(C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX);
        send_box(C_MIN, C_MIN, C_MIN, '0, '0, '0);
        send_box(C_MIN, C_MAX, C_MIN, H_MAX, '0, H_MAX);
    endtask

    // a box that exactly touches a plane passes, one step further it fails
    task automatic test_plane_touch();
        for (int i = 0; i < NUM_PLANES; i++)
            planes_next[i] = '0;
        planes_next[REG_LEFT] = pack_plane(N_ONE, '0, '0, 22'sd256);
        planes_next[REG_TOP]  = pack_plane('0, -N_ONE, '0, 22'sd512);
        program_planes();
        send_box('0, -22'sd512, '0, 21'd256, '0, '0);
        send_box('0, -22'sd512, '0, 21'd255, '0, '0);
        send_box(22'sd256, -22'sd512, '0, '0, '0, '0);
        send_box(22'sd255, -22'sd512, '0, '0, '0, '0);
        send_box(22'sd256, -22'sd511, '0, '0, '0, '0);
        send_box(22'sd256, '0, '0, '0, 21'd512, '0);
    endtask

    // most negative, all-ones and most positive plane words
    task automatic test_extreme_planes();
        for (int i = 0; i < NUM_PLANES; i++)
            planes_next[i] = (i < 3) ? pack_plane(N_MIN, N_MIN, N_MIN, C_MIN) : '1;
        program_planes();
        send_box(C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX);
        send_box(C_MIN, C_MIN, C_MIN, '0, '0, '0);
        send_box(C_MAX, C_MIN, C_MAX, '0, H_MAX, '0);
        for (int i = 0; i < NUM_PLANES; i++)
            planes_next[i] = pack_plane(N_MAX, N_MAX, N_MAX, C_MAX);
        program_planes();
        send_box(C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX);
        send_box(C_MIN, C_MIN, C_MIN, H_MAX, H_MAX, H_MAX);
        send_box(C_MAX, C_MAX, C_MAX, '0, '0, '0);
    endtask

    // writes to the two unused indexes must leave the planes alone
    task automatic test_ignored_index();
        for (int i = 0; i < NUM_PLANES; i++)
            planes_next[i] = '0;
        planes_next[REG_NEAR] = pack_plane('0, '0, N_ONE, '0);
        program_planes();
        write_cfg(REG_SPARE6, pack_plane(N_ONE, '0, '0, C_MAX));
        write_cfg(REG_SPARE7, '1);
        send_box('0, '0, '0, '0, '0, '0);
        send_box(22'sd4096, '0, 22'sd1, '0, '0, '0);
        send_box('0, '0, -22'sd1, '0, '0, 21'd1);
    endtask

    // random plane settings, each followed by a stream of boxes
    task automatic test_random_stream();
        bit                        idle_on;
        int                        pick;
        logic signed [COORD_W-1:0] cx, cy, cz;
        logic        [HALF_W-1:0]  hx, hy, hz;
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                pick = $urandom_range(0, 9);
                planes_next[i] = random_plane(pick < 5 ? PLANE_OPEN :
                                              pick < 7 ? PLANE_AXIS :
                                              pick < 9 ? PLANE_TILTED : PLANE_RAW);
            end
            program_planes();
            idle_on = (ph != PHASES - 1);
            for (int n = 0; n < PHASE_BOXES; n++) begin
                // switch between idle and back-to-back stretches
                if (ph != PHASES - 1 && n % 30 == 0)
                    idle_on = $urandom_range(0, 2) != 0;
                if (ph == PHASES / 2 && n == PHASE_BOXES / 2)
                    wait_drained();
                if ($urandom_range(0, 9) < 7) begin
                    // boxes near the origin, where the planes cut
                    cx = COORD_W'(int'($urandom_range(0, 2**18)) - 2**17);
                    cy = COORD_W'(int'($urandom_range(0, 2**18)) - 2**17);
                    cz = COORD_W'(int'($urandom_range(0, 2**18)) - 2**17);
                    hx = $urandom_range(0, 7) == 0 ? '0 : 21'($urandom_range(0, 2**14));
                    hy = HALF_W'($urandom_range(0, 2**14));
                    hz = HALF_W'($urandom_range(0, 2**14));
                end else begin
                    cx = COORD_W'($urandom);
                    cy = COORD_W'($urandom);
                    cz = COORD_W'($urandom);
                    hx = HALF_W'($urandom);
                    hy = HALF_W'($urandom);
                    hz = HALF_W'($urandom);
                end
                send_box(cx, cy, cz, hx, hy, hz);
                if (idle_on && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 14));
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_center_x  = '0;
        i_center_y  = '0;
        i_center_z  = '0;
        i_half_x    = '0;
        i_half_y    = '0;
        i_half_z    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int i = 0; i < NUM_PLANES; i++)
            plane_copy[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_planes();
        test_plane_touch();
        test_extreme_planes();
        test_ignored_index();
        test_random_stream();

        wait_drained();
        $display("sent %0d boxes over %0d plane settings", boxes_sent, plane_settings);
        $display("checked %0d results: %0d visible, %0d culled",
                 results_seen, visible_seen, results_seen - visible_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
